### rtl/egcd_pkg.sv
package egcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAX_STEPS  = DATA_WIDTH * 3 / 2 + 4;
    localparam int STEP_AW    = $clog2(MAX_STEPS);
    localparam int STEP_CW    = $clog2(MAX_STEPS + 1);
    localparam int BIT_CW     = $clog2(DATA_WIDTH);
    localparam int QUOT_W     = DATA_WIDTH + 1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_a;
        logic signed [DATA_WIDTH-1:0] value_b;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] coef_x;
        logic signed [DATA_WIDTH-1:0] coef_y;
    } out_item_t;

    typedef struct packed {
        logic               load_in;
        logic               div_init;
        logic               div_step;
        logic               div_commit;
        logic               set_one_zero;
        logic               set_zero_one;
        logic               mul_init;
        logic               mul_step;
        logic               back_commit;
        logic               out_load;
        logic [STEP_AW-1:0] ram_addr;
    } egcd_cmd_t;

    typedef struct packed {
        logic b_zero;
        logic rem_zero;
        logic mq_zero;
    } egcd_status_t;

endpackage

### rtl/egcd_ram.sv
module egcd_ram #(
    parameter int WIDTH = egcd_pkg::QUOT_W,
    parameter int DEPTH = egcd_pkg::MAX_STEPS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/egcd_dp.sv
module egcd_dp (
    input  logic                 aclk,
    input  egcd_pkg::in_item_t   s_data,
    input  egcd_pkg::egcd_cmd_t  cmd,
    output egcd_pkg::egcd_status_t status,
    output egcd_pkg::out_item_t  m_data
);

    localparam int W = egcd_pkg::DATA_WIDTH;

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic         nega_reg, nega_next;
    logic         negb_reg, negb_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] y_reg, y_next;
    logic [W-1:0] mq_reg, mq_next;
    logic         qneg_reg, qneg_next;
    logic [W-1:0] mcand_reg, mcand_next;
    logic [W-1:0] acc_reg, acc_next;
    egcd_pkg::out_item_t out_reg, out_next;

    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W:0]   trial;
    logic [W-1:0] prod;
    logic [egcd_pkg::QUOT_W-1:0] ram_wdata;
    logic [egcd_pkg::QUOT_W-1:0] ram_rdata;

    assign mag_a     = a_reg[W-1] ? (W'(0) - a_reg) : a_reg;
    assign mag_b     = b_reg[W-1] ? (W'(0) - b_reg) : b_reg;
    assign trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};
    assign prod      = qneg_reg ? (W'(0) - acc_reg) : acc_reg;
    assign ram_wdata = {nega_reg ^ negb_reg, quo_reg};

    egcd_ram #(
        .WIDTH(egcd_pkg::QUOT_W),
        .DEPTH(egcd_pkg::MAX_STEPS)
    ) u_quot_ram (
        .aclk   (aclk),
        .wr_en  (cmd.div_commit),
        .wr_addr(cmd.ram_addr),
        .wr_data(ram_wdata),
        .rd_addr(cmd.ram_addr),
        .rd_data(ram_rdata)
    );

    always_comb begin
        a_next     = a_reg;
        b_next     = b_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        nega_next  = nega_reg;
        negb_next  = negb_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        mq_next    = mq_reg;
        qneg_next  = qneg_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        out_next   = out_reg;

        if (cmd.load_in) begin
            a_next = s_data.value_a;
            b_next = s_data.value_b;
        end
        if (cmd.div_init) begin
            rem_next  = '0;
            quo_next  = mag_a;
            dvs_next  = mag_b;
            nega_next = a_reg[W-1];
            negb_next = b_reg[W-1];
        end
        if (cmd.div_step) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
            end else begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
            end
            quo_next = {quo_reg[W-2:0], ~trial[W]};
        end
        if (cmd.div_commit) begin
            a_next = b_reg;
            b_next = nega_reg ? (W'(0) - rem_reg) : rem_reg;
        end
        if (cmd.set_one_zero) begin
            x_next = W'(1);
            y_next = '0;
        end
        if (cmd.set_zero_one) begin
            x_next = '0;
            y_next = W'(1);
        end
        if (cmd.mul_init) begin
            mq_next    = ram_rdata[W-1:0];
            qneg_next  = ram_rdata[W];
            mcand_next = y_reg;
            acc_next   = '0;
        end
        if (cmd.mul_step) begin
            if (mq_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next = {mcand_reg[W-2:0], 1'b0};
            mq_next    = {1'b0, mq_reg[W-1:1]};
        end
        if (cmd.back_commit) begin
            x_next = y_reg;
            y_next = x_reg - prod;
        end
        if (cmd.out_load) begin
            out_next.coef_x = x_reg;
            out_next.coef_y = y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        nega_reg  <= nega_next;
        negb_reg  <= negb_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        mq_reg    <= mq_next;
        qneg_reg  <= qneg_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    assign status.b_zero   = (b_reg == '0);
    assign status.rem_zero = (rem_reg == '0);
    assign status.mq_zero  = (mq_reg == '0);
    assign m_data          = out_reg;

endmodule

### rtl/egcd_ctrl.sv
module egcd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  egcd_pkg::egcd_status_t status,
    output egcd_pkg::egcd_cmd_t    cmd
);

    localparam int CW = egcd_pkg::STEP_CW;
    localparam int AW = egcd_pkg::STEP_AW;
    localparam int BW = egcd_pkg::BIT_CW;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_CHECK  = 8'b00000010,
        ST_DIV    = 8'b00000100,
        ST_EVAL   = 8'b00001000,
        ST_BACK   = 8'b00010000,
        ST_READ   = 8'b00100000,
        ST_MUL    = 8'b01000000,
        ST_FINISH = 8'b10000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [BW-1:0]   bit_reg, bit_next;
    logic            m_valid_reg, m_valid_next;
    logic [CW-1:0]   step_dec;

    assign step_dec = step_reg - CW'(1);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        bit_next     = bit_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.ram_addr = step_reg[AW-1:0];
        s_ready      = 1'b0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    step_next   = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.b_zero) begin
                    cmd.set_one_zero = 1'b1;
                    state_next       = ST_BACK;
                end else begin
                    cmd.div_init = 1'b1;
                    bit_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + BW'(1);
                if (bit_reg == BW'(egcd_pkg::DATA_WIDTH - 1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.rem_zero) begin
                    cmd.set_zero_one = 1'b1;
                    state_next       = ST_BACK;
                end else if (step_reg == CW'(egcd_pkg::MAX_STEPS)) begin
                    cmd.set_one_zero = 1'b1;
                    state_next       = ST_BACK;
                end else begin
                    cmd.div_commit = 1'b1;
                    step_next      = step_reg + CW'(1);
                    state_next     = ST_CHECK;
                end
            end
            ST_BACK: begin
                cmd.ram_addr = step_dec[AW-1:0];
                if (step_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next  = step_dec;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.mul_init = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                if (status.mq_zero) begin
                    cmd.back_commit = 1'b1;
                    state_next      = ST_BACK;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        step_reg <= step_next;
        bit_reg  <= bit_next;
    end

    assign m_valid = m_valid_reg;

endmodule

### rtl/extended_gcd_bezout_unit.sv
// One item at a time. Each reduction step runs the bit-serial restoring divider
// over every bit of the dividend; each backward step runs the shift-add
// multiplier until the remaining quotient magnitude bits are zero. Reset clears
// the controller and the output valid; there is no clearing pass and no
// stored state across items.
module extended_gcd_bezout_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  egcd_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output egcd_pkg::out_item_t m_data
);

    egcd_pkg::egcd_cmd_t    cmd;
    egcd_pkg::egcd_status_t status;

    egcd_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    egcd_dp u_dp (
        .aclk  (aclk),
        .s_data(s_data),
        .cmd   (cmd),
        .status(status),
        .m_data(m_data)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int DATA_WIDTH  = egcd_pkg::DATA_WIDTH;
    localparam int MAX_STEPS   = egcd_pkg::MAX_STEPS;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_TAIL  = 2000;

    localparam logic [DATA_WIDTH-1:0] POS_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] NEG_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [63:0]           POS_MAX64 = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

    typedef struct {
        egcd_pkg::in_item_t  operands;
        egcd_pkg::out_item_t coefs;
    } bezout_case_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    egcd_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    egcd_pkg::out_item_t m_data;

    bezout_case_t pending_coefs[$];
    bezout_case_t got_case;
    int           pairs_sent;
    int           pairs_checked;
    int           error_count;
    int           cycle_count;
    bit           steady;

    extended_gcd_bezout_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Forward pass records truncating quotients, backward pass folds them into
    // the coefficients; all arithmetic is modulo 2^64 before the final truncation.
    function automatic egcd_pkg::out_item_t bezout_coefs(egcd_pkg::in_item_t item);
        logic [63:0]         num, den, quo, rem, mag_n, mag_d, cx, cy, t;
        logic [63:0]         quots[MAX_STEPS];
        int                  n;
        bit                  done;
        egcd_pkg::out_item_t res;
        num  = {{(64-DATA_WIDTH){item.value_a[DATA_WIDTH-1]}}, item.value_a};
        den  = {{(64-DATA_WIDTH){item.value_b[DATA_WIDTH-1]}}, item.value_b};
        n    = 0;
        done = 1'b0;
        cx   = 64'd1;
        cy   = 64'd0;
        while (!done) begin
            if (den == 64'd0) begin
                cx   = 64'd1;
                cy   = 64'd0;
                done = 1'b1;
            end else begin
                mag_n = num[63] ? 64'd0 - num : num;
                mag_d = den[63] ? 64'd0 - den : den;
                quo   = mag_n / mag_d;
                rem   = mag_n % mag_d;
                if (num[63] != den[63]) quo = 64'd0 - quo;
                if (num[63]) rem = 64'd0 - rem;
                if (rem == 64'd0) begin
                    cx   = 64'd0;
                    cy   = 64'd1;
                    done = 1'b1;
                end else if (n >= MAX_STEPS) begin
                    cx   = 64'd1;
                    cy   = 64'd0;
                    done = 1'b1;
                end else begin
                    quots[n] = quo;
                    n++;
                    num = den;
                    den = rem;
                end
            end
        end
        while (n > 0) begin
            n--;
            t  = cy;
            cy = cx - cy * quots[n];
            cx = t;
        end
        res.coef_x = cx[DATA_WIDTH-1:0];
        res.coef_y = cy[DATA_WIDTH-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // Consecutive Fibonacci numbers; a negative index picks the largest pair that fits.
    function automatic egcd_pkg::in_item_t fib_pair(int index);
        logic [63:0]        lo, hi, nxt;
        int                 k;
        egcd_pkg::in_item_t pair;
        lo  = 64'd1;
        hi  = 64'd1;
        nxt = 64'd2;
        k   = 0;
        while (nxt <= POS_MAX64 && (index < 0 || k < index)) begin
            lo  = hi;
            hi  = nxt;
            nxt = lo + hi;
            k++;
        end
        pair.value_a = hi[DATA_WIDTH-1:0];
        pair.value_b = lo[DATA_WIDTH-1:0];
        return pair;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_operand();
        logic [63:0]           raw;
        logic [DATA_WIDTH-1:0] v;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: v = '0;
                    1: v = 1;
                    2: v = '1;
                    3: v = POS_MAX;
                    4: v = -POS_MAX;
                    default: v = NEG_MIN;
                endcase
            end
            1, 2: v = $urandom_range(1, 200);
            3, 4: v = DATA_WIDTH'(raw[15:0]);
            default: v = raw[DATA_WIDTH-1:0];
        endcase
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    function automatic egcd_pkg::in_item_t rand_pair();
        egcd_pkg::in_item_t    pair;
        logic [DATA_WIDTH-1:0] g;
        case ($urandom_range(0, 9))
            0, 1: begin
                pair.value_b = $urandom_range(1, 5000);
                pair.value_a = pair.value_b * $urandom_range(0, 100000);
            end
            2, 3: begin
                pair = fib_pair($urandom_range(2, 60));
            end
            4: begin
                g            = $urandom_range(2, 1000);
                pair.value_a = g * $urandom_range(1, 1 << 20);
                pair.value_b = g * $urandom_range(1, 1 << 20);
            end
            5: begin
                pair.value_a = rand_operand();
                pair.value_b = '0;
                if ($urandom_range(0, 1) == 1) begin
                    pair.value_b = pair.value_a;
                    pair.value_a = '0;
                end
            end
            default: begin
                pair.value_a = rand_operand();
                pair.value_b = rand_operand();
            end
        endcase
        if ($urandom_range(0, 1) == 1) pair.value_a = -pair.value_a;
        if ($urandom_range(0, 1) == 1) pair.value_b = -pair.value_b;
        if ($urandom_range(0, 3) == 0) begin
            g            = pair.value_a;
            pair.value_a = pair.value_b;
            pair.value_b = g;
        end
        return pair;
    endfunction

    // Entered just after a rising edge; leaves at the edge where the item is taken.
    task automatic send_operands(egcd_pkg::in_item_t item);
        int           gap;
        bezout_case_t entry;
        gap = steady ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        entry.operands = item;
        entry.coefs    = bezout_coefs(item);
        pending_coefs.insert(pending_coefs.size(), entry);
        pairs_sent++;
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_coefs.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        egcd_pkg::in_item_t cases[$];
        cases.insert(cases.size(), '{value_a: 0, value_b: 0});
        cases.insert(cases.size(), '{value_a: 7, value_b: 0});
        cases.insert(cases.size(), '{value_a: 0, value_b: 7});
        cases.insert(cases.size(), '{value_a: 0, value_b: -7});
        cases.insert(cases.size(), '{value_a: POS_MAX, value_b: POS_MAX});
        cases.insert(cases.size(), '{value_a: POS_MAX, value_b: -POS_MAX});
        cases.insert(cases.size(), '{value_a: -POS_MAX, value_b: 1});
        cases.insert(cases.size(), '{value_a: NEG_MIN, value_b: 0});
        cases.insert(cases.size(), '{value_a: NEG_MIN, value_b: -1});
        cases.insert(cases.size(), '{value_a: NEG_MIN, value_b: NEG_MIN});
        cases.insert(cases.size(), '{value_a: NEG_MIN, value_b: POS_MAX});
        cases.insert(cases.size(), '{value_a: POS_MAX, value_b: NEG_MIN});
        cases.insert(cases.size(), '{value_a: 240, value_b: 46});
        cases.insert(cases.size(), '{value_a: -240, value_b: 46});
        cases.insert(cases.size(), '{value_a: 240, value_b: -46});
        cases.insert(cases.size(), '{value_a: -240, value_b: -46});
        cases.insert(cases.size(), '{value_a: 12, value_b: 4});
        cases.insert(cases.size(), '{value_a: 4, value_b: 12});
        cases.insert(cases.size(), '{value_a: 1, value_b: POS_MAX});
        cases.insert(cases.size(), '{value_a: POS_MAX, value_b: 2});
        cases.insert(cases.size(), fib_pair(-1));
        cases.insert(cases.size(),
                     '{value_a: -fib_pair(-1).value_a, value_b: fib_pair(-1).value_b});
        cases.insert(cases.size(),
                     '{value_a: fib_pair(-1).value_b, value_b: fib_pair(-1).value_a});
        foreach (cases[i]) send_operands(cases[i]);
    endtask

    task automatic test_random_operands(int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) pause_until_drained();
            send_operands(rand_pair());
        end
    endtask

    task automatic test_back_to_back(int count);
        steady = 1'b1;
        for (int i = 0; i < count; i++) send_operands(rand_pair());
        pause_until_drained();
        steady = 1'b0;
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!steady && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_coefs.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time,
                         m_data.coef_x, m_data.coef_y);
                error_count++;
            end else begin
                got_case = pending_coefs.pop_front();
                pairs_checked++;
                if (m_data.coef_x !== got_case.coefs.coef_x) begin
                    $display("%0t: coef_x for a=%0d b=%0d: expected %0d, actual %0d", $time,
                             got_case.operands.value_a, got_case.operands.value_b,
                             got_case.coefs.coef_x, m_data.coef_x);
                    error_count++;
                end
                if (m_data.coef_y !== got_case.coefs.coef_y) begin
                    $display("%0t: coef_y for a=%0d b=%0d: expected %0d, actual %0d", $time,
                             got_case.operands.value_a, got_case.operands.value_b,
                             got_case.coefs.coef_y, m_data.coef_y);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run stopped at the cycle limit, %0d results outstanding", $time,
                 pending_coefs.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        steady        = 1'b0;
        pairs_sent    = 0;
        pairs_checked = 0;
        error_count   = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_operands(360);
        test_back_to_back(30);

        pause_until_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);
        $display("Sent %0d operand pairs and checked %0d coefficient pairs: zero and extreme",
                 pairs_sent, pairs_checked);
        $display("operands, exact divisors, Fibonacci chains, random widths, stalls.");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
